// File: rtl/sdc_pkg.sv
// Package: types, constant tables and helper functions for the depth colorizer.
`default_nettype none

package sdc_pkg;

  // Number of class logits that take part in the argmax.
  localparam int NUM_CLASSES = 15;
  localparam int LOGIT_W     = 16;
  localparam int SLOT_N      = 16;
  localparam int CLASS_W     = 4;
  localparam int LEVEL_W     = 8;

  // Fixed-point operand: fp16 value times 2^24, saturated at +/-8.0.
  localparam int FIX_W       = 29;
  localparam int MAG_W       = 28;
  localparam int FIX_FRAC    = 24;
  // Exponent code at and above which |x| >= 8.0.
  localparam logic [4:0] EXP_SAT = 5'd18;

  // One threshold for each level step 1..255.
  localparam int THR_N       = 255;

  localparam real FIX_SCALE  = 16777216.0;
  // Depth: level k is reached once exp(x) >= k * 200 / 255.
  localparam real DEPTH_STEP = 200.0 / 255.0;
  // Scale: level k is reached once exp(x) >= k * 403.4288 / 255.
  localparam real SCALE_STEP = 252143.0 / 159375.0;

  typedef logic signed [FIX_W-1:0]   fix_t;
  typedef logic signed [LOGIT_W-1:0] key_t;
  typedef fix_t thr_table_t [THR_N];

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } color_t;

  // Lowest key, below every real logit key, for unused tournament slots.
  localparam key_t KEY_FLOOR = 16'sh8000;

  // Upper clamp of the log-scale operand: 6.0 in fixed point.
  localparam fix_t SCALE_TOP = fix_t'(6 * (1 << FIX_FRAC));

  // Smallest fixed-point operand that reaches each level, rounded up.
  function automatic thr_table_t build_thr(input real step);
    thr_table_t tab;
    real        v;
    for (int k = 0; k < THR_N; k++) begin
      v = $ln(real'(k + 1) * step) * FIX_SCALE;
      tab[k] = fix_t'($rtoi($ceil(v)));
    end
    return tab;
  endfunction

  localparam thr_table_t DEPTH_THR = build_thr(DEPTH_STEP);
  localparam thr_table_t SCALE_THR = build_thr(SCALE_STEP);

  // fp16 code to x * 2^24; infinity, NaN and |x| >= 8 saturate at 8.0.
  function automatic fix_t fp16_fix(input logic [15:0] h);
    logic [4:0]       e;
    logic [9:0]       m;
    logic [MAG_W-1:0] mag;
    fix_t             pos;
    e = h[14:10];
    m = h[9:0];
    if (e >= EXP_SAT) begin
      mag = MAG_W'(1) << (MAG_W - 1);
    end else if (e == 5'd0) begin
      mag = MAG_W'(m);
    end else begin
      mag = MAG_W'({1'b1, m}) << (e - 5'd1);
    end
    pos = fix_t'({1'b0, mag});
    return h[15] ? -pos : pos;
  endfunction

  // Sign-magnitude logit code to a two's complement key; -0 equals +0.
  function automatic key_t logit_key(input logic [LOGIT_W-1:0] h);
    key_t mag;
    mag = key_t'({1'b0, h[LOGIT_W-2:0]});
    return h[LOGIT_W-1] ? -mag : mag;
  endfunction

  // Class colors in file byte order (blue, green, red).
  function automatic color_t class_color(input logic [CLASS_W-1:0] c);
    color_t col;
    case (c)
      4'd0:    col = '{8'd200, 8'd0,   8'd210};
      4'd1:    col = '{8'd255, 8'd200, 8'd90};
      4'd2:    col = '{8'd0,   8'd199, 8'd0};
      4'd3:    col = '{8'd0,   8'd240, 8'd90};
      4'd4:    col = '{8'd140, 8'd140, 8'd140};
      4'd5:    col = '{8'd100, 8'd60,  8'd100};
      4'd6:    col = '{8'd255, 8'd100, 8'd250};
      4'd7:    col = '{8'd0,   8'd255, 8'd255};
      4'd8:    col = '{8'd0,   8'd200, 8'd200};
      4'd9:    col = '{8'd0,   8'd130, 8'd255};
      4'd10:   col = '{8'd80,  8'd80,  8'd80};
      4'd11:   col = '{8'd60,  8'd60,  8'd160};
      4'd12:   col = '{8'd80,  8'd127, 8'd255};
      4'd13:   col = '{8'd139, 8'd139, 8'd0};
      4'd14:   col = '{8'd0,   8'd0,   8'd0};
      default: col = '0;
    endcase
    return col;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sdc_classify.sv
// Class argmax over the logits by a tournament tree, plus the class color lookup.
`default_nettype none

module sdc_classify (
  input  wire logic [63:0]                   logits_low,
  input  wire logic [63:0]                   logits_mid,
  input  wire logic [63:0]                   logits_high,
  input  wire logic [47:0]                   logits_top,
  output logic      [sdc_pkg::CLASS_W-1:0]   class_index,
  output sdc_pkg::color_t                    color
);
  import sdc_pkg::*;

  logic [SLOT_N*LOGIT_W-1:0] all_logits;
  key_t                      key0 [16];
  logic [CLASS_W-1:0]        idx0 [16];
  key_t                      key1 [8];
  logic [CLASS_W-1:0]        idx1 [8];
  key_t                      key2 [4];
  logic [CLASS_W-1:0]        idx2 [4];
  key_t                      key3 [2];
  logic [CLASS_W-1:0]        idx3 [2];

  assign all_logits = {{LOGIT_W{1'b0}}, logits_top, logits_high, logits_mid, logits_low};

  // Each match keeps the left (lower) class unless the right one is strictly greater.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      key0[i] = (i < NUM_CLASSES) ? logit_key(all_logits[i*LOGIT_W +: LOGIT_W]) : KEY_FLOOR;
      idx0[i] = CLASS_W'(i);
    end
    for (int i = 0; i < 8; i++) begin
      if (key0[2*i+1] > key0[2*i]) begin
        key1[i] = key0[2*i+1];
        idx1[i] = idx0[2*i+1];
      end else begin
        key1[i] = key0[2*i];
        idx1[i] = idx0[2*i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (key1[2*i+1] > key1[2*i]) begin
        key2[i] = key1[2*i+1];
        idx2[i] = idx1[2*i+1];
      end else begin
        key2[i] = key1[2*i];
        idx2[i] = idx1[2*i];
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (key2[2*i+1] > key2[2*i]) begin
        key3[i] = key2[2*i+1];
        idx3[i] = idx2[2*i+1];
      end else begin
        key3[i] = key2[2*i];
        idx3[i] = idx2[2*i];
      end
    end
    class_index = (key3[1] > key3[0]) ? idx3[1] : idx3[0];
  end

  assign color = class_color(class_index);

endmodule

`default_nettype wire

// File: rtl/sdc_level.sv
// Threshold compare bank and thermometer-to-binary encoder for one exp level.
`default_nettype none

module sdc_level (
  input  wire sdc_pkg::fix_t                 x,
  input  wire sdc_pkg::thr_table_t           thr,
  output logic      [sdc_pkg::LEVEL_W-1:0]   level
);
  import sdc_pkg::*;

  logic [THR_N-1:0]   th;
  logic [LEVEL_W-1:0] acc;
  logic [LEVEL_W-1:0] probe;

  // Thresholds rise with k, so th is a thermometer code.
  always_comb begin
    for (int k = 0; k < THR_N; k++) begin
      th[k] = (x >= thr[k]);
    end
  end

  // Binary search on the thermometer: one level bit per step, MSB first.
  always_comb begin
    acc   = '0;
    probe = '0;
    for (int b = LEVEL_W - 1; b >= 0; b--) begin
      probe = acc | (LEVEL_W'(1) << b);
      if (th[probe - LEVEL_W'(1)]) begin
        acc = probe;
      end
    end
    level = acc;
  end

endmodule

`default_nettype wire

// File: rtl/segmentation_depth_colorize.sv
// Top level: per-pixel class colorizer with depth and uncertainty levels.
`default_nettype none

// Channel  | Ports                                         | Direction
// ---------+-----------------------------------------------+----------
// in_      | valid, stall, 15 fp16 logits, ln_depth/scale  | request in
// out_     | valid, stall, class, 3 color bytes, 2 levels  | request out
//
// One request per cycle sustained while out_stall is low; each request passes through
// the input register, then the result register.
// All class, depth and scale logic sits between those two registers.
// rst_n is synchronous, active low, and empties both stages.
// A stalled result holds in the result register while the input register still
// takes a request; in_stall rises only when both stages are full and out_stall is high.
module segmentation_depth_colorize (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_logits_low,
  input  wire logic [63:0] in_logits_mid,
  input  wire logic [63:0] in_logits_high,
  input  wire logic [47:0] in_logits_top,
  input  wire logic [15:0] in_ln_depth,
  input  wire logic [15:0] in_log_scale,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_class_index,
  output logic [7:0]       out_color_first,
  output logic [7:0]       out_color_second,
  output logic [7:0]       out_color_third,
  output logic [7:0]       out_depth_level,
  output logic [7:0]       out_uncertainty_level
);
  import sdc_pkg::*;

  // Input register stage.
  logic               s1_valid_r;
  logic [63:0]        s1_low_r;
  logic [63:0]        s1_mid_r;
  logic [63:0]        s1_high_r;
  logic [47:0]        s1_top_r;
  logic [15:0]        s1_depth_r;
  logic [15:0]        s1_scale_r;

  // Result register stage.
  logic               out_valid_r;
  logic [CLASS_W-1:0] out_class_r;
  color_t             out_color_r;
  logic [LEVEL_W-1:0] out_depth_r;
  logic [LEVEL_W-1:0] out_unc_r;

  logic               s2_load;
  logic               s1_load;
  logic               out_valid_nxt;

  logic [CLASS_W-1:0] class_nxt;
  color_t             color_nxt;
  logic [LEVEL_W-1:0] depth_nxt;
  logic [LEVEL_W-1:0] unc_nxt;
  fix_t               depth_x;
  fix_t               scale_raw;
  fix_t               scale_x;

  // Advance the result stage whenever it is empty or being drained.
  assign s2_load  = !out_valid_r || !out_stall;
  // Advance the input stage whenever it is empty or passing its request on.
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  assign out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture a new request only when one is offered and the stage advances.
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_low_r   <= in_logits_low;
      s1_mid_r   <= in_logits_mid;
      s1_high_r  <= in_logits_high;
      s1_top_r   <= in_logits_top;
      s1_depth_r <= in_ln_depth;
      s1_scale_r <= in_log_scale;
    end
  end

  // Argmax over the logits, lowest class on ties, and its color.
  sdc_classify u_classify (
    .logits_low  (s1_low_r),
    .logits_mid  (s1_mid_r),
    .logits_high (s1_high_r),
    .logits_top  (s1_top_r),
    .class_index (class_nxt),
    .color       (color_nxt)
  );

  // Depth: below every threshold gives 0, above the last gives 255, so no clamp.
  assign depth_x = fp16_fix(s1_depth_r);

  sdc_level u_depth_level (
    .x     (depth_x),
    .thr   (DEPTH_THR),
    .level (depth_nxt)
  );

  // Scale: clamp at 6.0 so the top lands on 254; exp(6) stays under the last step.
  assign scale_raw = fp16_fix(s1_scale_r);
  assign scale_x   = (scale_raw > SCALE_TOP) ? SCALE_TOP : scale_raw;

  sdc_level u_scale_level (
    .x     (scale_x),
    .thr   (SCALE_THR),
    .level (unc_nxt)
  );

  // Load the result register when the input stage holds a request and it advances.
  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_class_r <= class_nxt;
      out_color_r <= color_nxt;
      out_depth_r <= depth_nxt;
      out_unc_r   <= unc_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_class_index       = out_class_r;
  assign out_color_first       = out_color_r.first;
  assign out_color_second      = out_color_r.second;
  assign out_color_third       = out_color_r.third;
  assign out_depth_level       = out_depth_r;
  assign out_uncertainty_level = out_unc_r;

  // An accepted request always lands in the input stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted request did not reach the input stage");

  // A full input stage behind a stalled result must hold its request.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("input stage dropped a request under stall");

  // The winning class is always one of the compared classes.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_class_index <= CLASS_W'(NUM_CLASSES - 1))
    else $error("class index out of range");

  // The clamped scale never reaches the top level.
  a_scale_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_uncertainty_level != 8'd255)
    else $error("uncertainty level reached 255");

endmodule

`default_nettype wire
